// ----- sv/oees_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oees_pkg
// Shared widths, mode and status codes, controller/datapath command and
// status structs, and the default order key table.
// ----------------------------------------------------------------------------
package oees_pkg;

    localparam int ID_W     = 6;
    localparam int KEY_W    = 8;
    localparam int CNT_W    = 7;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int COMP_W   = KEY_W + ID_W;
    localparam int BIT_W    = 4;
    localparam int ID_LIMIT = 64;

    localparam logic [CNT_W-1:0] DEF_COUNT  = 7'd51;
    localparam logic [KEY_W-1:0] KEY_ABSENT = 8'd255;
    localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(COMP_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_NEXT,
        MODE_PREV,
        MODE_SELECT,
        MODE_ENABLE,
        MODE_DISABLE,
        MODE_SET_ORDER,
        MODE_AT_RANK,
        MODE_POSITION
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_BAD_ARG,
        ST_DISABLED,
        ST_NO_RANK
    } t_status;

    typedef struct packed {
        logic             load;
        logic             apply;
        logic             scan_clr;
        logic             scan_issue;
        logic             thr_cur;
        logic             eval;
        logic             srch_init;
        logic             trial;
        logic             srch_upd;
        logic             out_load;
        logic [BIT_W-1:0] bit_pos;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  scan_last;
        logic  out_free;
    } t_stat;

    function automatic logic [KEY_W-1:0] default_key(input logic [ID_W-1:0] idx);
        logic [KEY_W-1:0] k;
        case (idx)
            6'd0:  k = 8'd0;    6'd1:  k = 8'd5;    6'd2:  k = 8'd6;    6'd3:  k = 8'd7;
            6'd4:  k = 8'd8;    6'd5:  k = 8'd10;   6'd6:  k = 8'd20;   6'd7:  k = 8'd25;
            6'd8:  k = 8'd26;   6'd9:  k = 8'd30;   6'd10: k = 8'd35;   6'd11: k = 8'd40;
            6'd12: k = 8'd45;   6'd13: k = 8'd50;   6'd14: k = 8'd55;   6'd15: k = 8'd60;
            6'd16: k = 8'd65;   6'd17: k = 8'd66;   6'd18: k = 8'd70;   6'd19: k = 8'd75;
            6'd20: k = 8'd80;   6'd21: k = 8'd85;   6'd22: k = 8'd1;    6'd23: k = 8'd2;
            6'd24: k = 8'd90;   6'd25: k = 8'd95;   6'd26: k = 8'd100;  6'd27: k = 8'd110;
            6'd28: k = 8'd111;  6'd29: k = 8'd112;  6'd30: k = 8'd113;  6'd31: k = 8'd114;
            6'd32: k = 8'd115;  6'd33: k = 8'd116;  6'd34: k = 8'd120;  6'd35: k = 8'd121;
            6'd36: k = 8'd122;  6'd37: k = 8'd130;  6'd38: k = 8'd131;  6'd39: k = 8'd140;
            6'd40: k = 8'd145;  6'd41: k = 8'd150;  6'd42: k = 8'd155;  6'd43: k = 8'd160;
            6'd44: k = 8'd165;  6'd45: k = 8'd170;  6'd46: k = 8'd175;  6'd47: k = 8'd200;
            6'd48: k = 8'd205;  6'd49: k = 8'd207;  6'd50: k = 8'd250;
            default: k = KEY_ABSENT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- sv/oees_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oees_in_if
// Request channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface oees_in_if;
    import oees_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic [KEY_W-1:0]  order_value;
    logic [ID_W-1:0]   rank_query;

    modport source (output valid, mode, entry_id, order_value, rank_query, input ready);
    modport sink   (input valid, mode, entry_id, order_value, rank_query, output ready);
endinterface
`default_nettype wire

// ----- sv/oees_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oees_out_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface oees_out_if;
    import oees_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   current_out;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   found_entry;
    logic              found_valid;
    logic [ID_W-1:0]   current_rank;
    logic [CNT_W-1:0]  enabled_total;

    modport source (output valid, current_out, status, found_entry, found_valid,
                    current_rank, enabled_total, input ready);
    modport sink   (input valid, current_out, status, found_entry, found_valid,
                    current_rank, enabled_total, output ready);
endinterface
`default_nettype wire

// ----- sv/oees_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oees_ctrl
// Sequencer: apply the command, run one scan over the table, evaluate, and
// for rank lookups run a bitwise search of scan passes before the result.
// ----------------------------------------------------------------------------
module oees_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  oees_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output oees_pkg::t_cmd o_cmd
);
    import oees_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_CURRD,
        S_CURCAP,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_TRIAL,
        S_SRCH_UPD,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_search, n_search;

    always_comb begin
        o_cmd         = '0;
        o_cmd.bit_pos = r_bit;
        o_in_ready    = 1'b0;
        n_state       = r_state;
        n_bit         = r_bit;
        n_search      = r_search;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_CURRD;
            end
            S_CURRD: begin
                // read port addresses the current entry by default
                n_state = S_CURCAP;
            end
            S_CURCAP: begin
                o_cmd.thr_cur  = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_search ? S_SRCH_UPD : S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.mode == MODE_AT_RANK) begin
                    o_cmd.srch_init = 1'b1;
                    n_search        = 1'b1;
                    n_bit           = LAST_BIT;
                    n_state         = S_TRIAL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_TRIAL: begin
                o_cmd.trial    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_SRCH_UPD: begin
                o_cmd.srch_upd = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_TRIAL;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_search       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bit    <= '0;
            r_search <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bit    <= n_bit;
            r_search <= n_search;
        end
    end
endmodule
`default_nettype wire

// ----- sv/oees_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oees_dpath
// Entry table (enable flops, key memory with per-entry written flags),
// current entry, scan accumulators, rank search and result register.
// ----------------------------------------------------------------------------
module oees_dpath #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [oees_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic [oees_pkg::MODE_W-1:0]   i_mode,
    input  logic [oees_pkg::ID_W-1:0]     i_entry_id,
    input  logic [oees_pkg::KEY_W-1:0]    i_order_value,
    input  logic [oees_pkg::ID_W-1:0]     i_rank_query,
    input  oees_pkg::t_cmd                i_cmd,
    output oees_pkg::t_stat               o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [oees_pkg::ID_W-1:0]     o_current_out,
    output logic [oees_pkg::STAT_W-1:0]   o_status,
    output logic [oees_pkg::ID_W-1:0]     o_found_entry,
    output logic                          o_found_valid,
    output logic [oees_pkg::ID_W-1:0]     o_current_rank,
    output logic [oees_pkg::CNT_W-1:0]    o_enabled_total
);
    import oees_pkg::*;

    localparam int CAP   = (MAX_ENTRIES < ID_LIMIT) ? MAX_ENTRIES : ID_LIMIT;
    localparam int IDX_W = $clog2(CAP);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    // configuration and latched command
    logic [CNT_W-1:0]  r_cfg;
    t_mode             r_mode;
    logic [ID_W-1:0]   r_id;
    logic [KEY_W-1:0]  r_ord;
    logic [ID_W-1:0]   r_rq;
    t_status           r_status;
    logic              r_move;
    logic [ID_W-1:0]   r_cur;

    // table
    logic [CAP-1:0]    r_en;
    logic [CAP-1:0]    r_kv;
    logic [KEY_W-1:0]  mem [CAP];

    // read pipe
    logic [KEY_W-1:0]  r_rd_key;
    logic              r_rd_kv;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_live;
    logic [IDX_W-1:0]  r_idx;

    // scan accumulators
    logic [COMP_W-1:0] r_thr, r_prefix;
    logic [CNT_W-1:0]  r_cnt_all, r_cnt_lt, r_cnt_le;
    logic [COMP_W-1:0] r_min_gt, r_max_lt, r_min_all, r_max_all;
    logic              r_have_gt, r_have_lt, r_have_all;

    logic [ID_W-1:0]   r_rank;
    logic [CNT_W-1:0]  r_total;

    logic [CNT_W-1:0]  n_live;
    logic              id_bad;
    logic [IDX_W-1:0]  id_idx, cur_idx, rd_addr;
    logic [KEY_W-1:0]  key_eff;
    logic [COMP_W-1:0] comp;
    logic              live;
    logic [ID_W-1:0]   n_cur;
    logic [CNT_W-1:0]  rank_raw;
    logic              forward;
    logic              rank_hit;

    always_comb begin
        if (r_cfg == '0) begin
            n_live = CNT_W'(1);
        end else if (r_cfg > CAP_CNT) begin
            n_live = CAP_CNT;
        end else begin
            n_live = r_cfg;
        end
    end

    assign id_bad   = CNT_W'(r_id) >= n_live;
    assign id_idx   = r_id[IDX_W-1:0];
    assign cur_idx  = r_cur[IDX_W-1:0];
    assign rd_addr  = i_cmd.scan_issue ? r_idx : cur_idx;
    assign key_eff  = r_rd_kv ? r_rd_key : default_key(ID_W'(r_rd_idx));
    assign comp     = {key_eff, ID_W'(r_rd_idx)};
    assign live     = r_rd_live && r_en[r_rd_idx];
    assign rank_hit = CNT_W'(r_rq) < r_total;

    assign o_stat.mode      = r_mode;
    assign o_stat.scan_last = (CNT_W'(r_idx) == n_live - 1'b1);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    // new current entry and its rank from the accumulators
    always_comb begin
        forward  = (r_mode == MODE_NEXT) || ((r_mode == MODE_DISABLE) && r_move);
        n_cur    = r_cur;
        rank_raw = r_cnt_lt;
        if (forward) begin
            rank_raw = '0;
            if (r_have_gt) begin
                n_cur    = r_min_gt[ID_W-1:0];
                rank_raw = r_cnt_le;
            end else if (r_have_all) begin
                n_cur = r_min_all[ID_W-1:0];
            end else if (r_move) begin
                n_cur = '0;
            end
        end else if (r_mode == MODE_PREV) begin
            rank_raw = '0;
            if (r_have_lt) begin
                n_cur    = r_max_lt[ID_W-1:0];
                rank_raw = r_cnt_lt - 1'b1;
            end else if (r_have_all) begin
                n_cur    = r_max_all[ID_W-1:0];
                rank_raw = r_cnt_all - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= DEF_COUNT;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_id   <= i_entry_id;
            r_ord  <= i_order_value;
            r_rq   <= i_rank_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_en     <= '1;
            r_kv     <= '0;
            r_status <= ST_OK;
            r_move   <= 1'b0;
        end else if (i_cmd.load) begin
            r_status <= ST_OK;
            r_move   <= 1'b0;
        end else if (i_cmd.apply) begin
            case (r_mode)
                MODE_SELECT: begin
                    if (id_bad) begin
                        r_status <= ST_BAD_ARG;
                    end else if (!r_en[id_idx]) begin
                        r_status <= ST_DISABLED;
                    end else begin
                        r_cur <= r_id;
                    end
                end
                MODE_ENABLE: begin
                    if (id_bad) begin
                        r_status <= ST_BAD_ARG;
                    end else begin
                        r_en[id_idx] <= 1'b1;
                    end
                end
                MODE_DISABLE: begin
                    // entry 0 is the home entry and stays enabled
                    if (id_bad || r_id == '0) begin
                        r_status <= ST_BAD_ARG;
                    end else begin
                        r_en[id_idx] <= 1'b0;
                        r_move       <= (r_cur == r_id);
                    end
                end
                MODE_SET_ORDER: begin
                    if (id_bad) begin
                        r_status <= ST_BAD_ARG;
                    end else begin
                        r_kv[id_idx] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.eval) begin
            r_cur <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && r_mode == MODE_SET_ORDER && !id_bad) begin
            mem[id_idx] <= r_ord;
        end
        r_rd_key <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.scan_issue;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_kv  <= r_kv[rd_addr];
        r_rd_idx <= rd_addr;
    end

    // one entry per cycle against the threshold
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_cnt_all  <= '0;
            r_cnt_lt   <= '0;
            r_cnt_le   <= '0;
            r_have_gt  <= 1'b0;
            r_have_lt  <= 1'b0;
            r_have_all <= 1'b0;
        end else if (live) begin
            r_cnt_all <= r_cnt_all + 1'b1;
            if (comp < r_thr) begin
                r_cnt_lt <= r_cnt_lt + 1'b1;
            end
            if (comp <= r_thr) begin
                r_cnt_le <= r_cnt_le + 1'b1;
            end
            if (comp > r_thr && (!r_have_gt || comp < r_min_gt)) begin
                r_min_gt  <= comp;
                r_have_gt <= 1'b1;
            end
            if (comp < r_thr && (!r_have_lt || comp > r_max_lt)) begin
                r_max_lt  <= comp;
                r_have_lt <= 1'b1;
            end
            if (!r_have_all || comp < r_min_all) begin
                r_min_all <= comp;
            end
            if (!r_have_all || comp > r_max_all) begin
                r_max_all <= comp;
            end
            r_have_all <= 1'b1;
        end
    end

    // threshold and rank search
    always_ff @(posedge i_clk) begin
        if (i_cmd.thr_cur) begin
            r_thr <= comp;
        end else if (i_cmd.trial) begin
            r_thr <= r_prefix | (COMP_W'(1) << i_cmd.bit_pos);
        end
        if (i_cmd.srch_init) begin
            r_prefix <= '0;
        end else if (i_cmd.srch_upd && r_cnt_lt <= CNT_W'(r_rq)) begin
            r_prefix <= r_thr;
        end
        if (i_cmd.eval) begin
            r_total <= r_cnt_all;
            r_rank  <= (rank_raw >= r_cnt_all) ? '0 : rank_raw[ID_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_current_out   <= r_cur;
            o_current_rank  <= r_rank;
            o_enabled_total <= r_total;
            if (r_mode == MODE_AT_RANK) begin
                o_status      <= rank_hit ? ST_OK : ST_NO_RANK;
                o_found_valid <= rank_hit;
                o_found_entry <= rank_hit ? r_prefix[ID_W-1:0] : '0;
            end else begin
                o_status      <= r_status;
                o_found_valid <= 1'b0;
                o_found_entry <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/ordered_enabled_entry_selector.sv -----
`default_nettype none
// A request is applied, then the clamped entry count of table entries is scanned, one
// table entry per cycle through the key RAM read port; the entry-at-rank mode adds a
// bitwise search of further scan passes, one per bit of the composite key. A finished
// result waits in the output register while the next request runs; a new request is
// taken only after the previous result is loaded there. Reset is synchronous, active low:
// all entries enabled, default order keys, current entry 0, entry count 51.
// ----------------------------------------------------------------------------
// ordered_enabled_entry_selector
// Entry table ranked by order key with a current entry: navigation, enable,
// disable, re-keying and rank lookups, one request at a time.
// ----------------------------------------------------------------------------
module ordered_enabled_entry_selector #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [oees_pkg::CNT_W-1:0] i_cfg_wr_data,
    oees_in_if.sink                    i_in_ch,
    oees_out_if.source                 o_out_ch
);
    import oees_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in_ch.ready = w_in_ready;

    oees_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    oees_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (i_in_ch.mode),
        .i_entry_id      (i_in_ch.entry_id),
        .i_order_value   (i_in_ch.order_value),
        .i_rank_query    (i_in_ch.rank_query),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (o_out_ch.ready),
        .o_out_valid     (o_out_ch.valid),
        .o_current_out   (o_out_ch.current_out),
        .o_status        (o_out_ch.status),
        .o_found_entry   (o_out_ch.found_entry),
        .o_found_valid   (o_out_ch.found_valid),
        .o_current_rank  (o_out_ch.current_rank),
        .o_enabled_total (o_out_ch.enabled_total)
    );
endmodule
`default_nettype wire
